[rtl/core/slmc_pkg.sv]
// ----------------------------------------------------------------------------
// Stopwatch lap mode controller package
// Shared codes, the one-hot mode type and the result record passed between
// the control core and the lap formatting pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package slmc_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_TIMEOUT = 1'b1;

   localparam logic [CSR_DATA_W-1:0] LONG_PRESS_RESET   = 16'd3000;
   localparam logic [CSR_DATA_W-1:0] IDLE_TIMEOUT_RESET = 16'd5000;

   localparam logic [1:0] OP_PRESS   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_POLL    = 2'd2;

   localparam logic [1:0] KEY_UP     = 2'd0;
   localparam logic [1:0] KEY_DOWN   = 2'd1;
   localparam logic [1:0] KEY_SELECT = 2'd2;
   localparam logic [1:0] KEY_OTHER  = 2'd3;

   localparam logic [2:0] MODE_CODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_CODE_COUNT = 3'd1;
   localparam logic [2:0] MODE_CODE_PAUSE = 3'd2;
   localparam logic [2:0] MODE_CODE_VIEW  = 3'd3;
   localparam logic [2:0] MODE_CODE_DIM   = 3'd4;

   localparam logic [1:0] STORE_NONE   = 2'd0;
   localparam logic [1:0] STORE_STORED = 2'd1;
   localparam logic [1:0] STORE_FULL   = 2'd2;

   localparam logic [1:0] VIEW_NONE  = 2'd0;
   localparam logic [1:0] VIEW_SHOWN = 2'd1;
   localparam logic [1:0] VIEW_EMPTY = 2'd2;

   localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
   localparam logic [31:0] DIV15_MAGIC = 32'h8888_8889;

   typedef enum logic [4:0] {
      MODE_IDLE  = 5'b00001,
      MODE_COUNT = 5'b00010,
      MODE_PAUSE = 5'b00100,
      MODE_VIEW  = 5'b01000,
      MODE_DIM   = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       running;
      logic       clear_count;
      logic [1:0] store_status;
      logic [3:0] lap_slot;
      logic [1:0] view_status;
      logic [2:0] dim_level;
      logic [7:0] pwm_duty;
      logic [6:0] dim_percent;
   } rsp_core_type;

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] code;
      unique case (m)
         MODE_IDLE:  code = MODE_CODE_IDLE;
         MODE_COUNT: code = MODE_CODE_COUNT;
         MODE_PAUSE: code = MODE_CODE_PAUSE;
         MODE_VIEW:  code = MODE_CODE_VIEW;
         MODE_DIM:   code = MODE_CODE_DIM;
         default:    code = MODE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[rtl/core/slmc_ctrl.sv]
// ----------------------------------------------------------------------------
// Stopwatch lap mode controller core
// Holds the mode state, the lap store and the backlight level, and turns one
// keypad event into the next state and the result record in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module slmc_ctrl #(
   parameter int LAP_SLOTS  = 10,
   parameter int DIM_LEVELS = 5
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [slmc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [slmc_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  wire logic                               fire,
   input  wire logic [1:0]                         item_operation,
   input  wire logic [1:0]                         item_key,
   input  wire logic [31:0]                        item_now_ms,
   input  wire logic [31:0]                        item_count_value,
   output slmc_pkg::rsp_core_type                  core,
   output logic [31:0]                             lap_value
);
   import slmc_pkg::*;

   localparam int SLOT_W = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
   localparam int CNT_W  = $clog2(LAP_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(LAP_SLOTS);
   localparam logic [2:0] LEVEL_MAX   = 3'(DIM_LEVELS - 1);
   localparam logic [2:0] LEVEL_RESET = (DIM_LEVELS - 1 < 3) ? 3'(DIM_LEVELS - 1) : 3'd3;

   mode_type                  mode_ff, mode_in;
   logic                      running_ff, running_in;
   logic [CNT_W-1:0]          laps_ff, laps_in;
   logic [SLOT_W-1:0]         view_ff, view_in;
   logic [31:0]               press_ff, press_in;
   logic [31:0]               last_ff, last_in;
   logic [2:0]                level_ff, level_in;
   logic [CSR_DATA_W-1:0]     long_press_ff, idle_timeout_ff;
   logic [31:0]               lap_store [LAP_SLOTS];
   logic                      store_we;
   logic                      show;
   logic                      report;
   logic                      from_count;
   logic [SLOT_W-1:0]         rep_slot;
   logic                      clear;
   logic [1:0]                store_status;
   logic [1:0]                view_status;
   logic [31:0]               hold_time;
   logic [31:0]               idle_time;
   logic [31:0]               rd_data;
   logic [7:0]                duty_tab [8];
   logic [6:0]                pct_tab [8];

   for (genvar g = 0; g < 8; g++) begin : g_level
      localparam int DUTY_G = (g < DIM_LEVELS) ? 255 * (g + 1) / DIM_LEVELS : 0;
      localparam int PCT_G  = DUTY_G * 100 / 255;
      assign duty_tab[g] = 8'(DUTY_G);
      assign pct_tab[g]  = 7'(PCT_G);
   end

   assign hold_time = item_now_ms - press_ff;
   assign idle_time = item_now_ms - last_ff;
   assign rd_data   = lap_store[view_in];

   always_comb begin
      mode_in      = mode_ff;
      running_in   = running_ff;
      laps_in      = laps_ff;
      view_in      = view_ff;
      press_in     = press_ff;
      last_in      = last_ff;
      level_in     = level_ff;
      store_we     = 1'b0;
      show         = 1'b0;
      report       = 1'b0;
      from_count   = 1'b0;
      rep_slot     = '0;
      clear        = 1'b0;
      store_status = STORE_NONE;
      view_status  = VIEW_NONE;

      case (item_operation)
         OP_PRESS: begin
            if (mode_ff == MODE_IDLE) begin
               if (item_key != KEY_OTHER) begin
                  mode_in    = MODE_COUNT;
                  running_in = 1'b1;
                  clear      = 1'b1;
               end
            end else begin
               case (item_key)
                  KEY_UP: begin
                     case (mode_ff)
                        MODE_COUNT: begin
                           running_in = 1'b0;
                           mode_in    = MODE_PAUSE;
                        end
                        MODE_PAUSE: begin
                           running_in = 1'b1;
                           mode_in    = MODE_COUNT;
                        end
                        MODE_VIEW: begin
                           if ((CNT_W + 1)'(view_ff) + 1'b1 < (CNT_W + 1)'(laps_ff)) begin
                              view_in = SLOT_W'(view_ff + 1'b1);
                           end
                           show = 1'b1;
                        end
                        MODE_DIM: begin
                           last_in = item_now_ms;
                           if (level_ff < LEVEL_MAX) begin
                              level_in = 3'(level_ff + 1'b1);
                           end
                        end
                        default: ;
                     endcase
                  end
                  KEY_DOWN: begin
                     case (mode_ff)
                        MODE_COUNT, MODE_PAUSE: begin
                           if (laps_ff < SLOTS_CNT) begin
                              store_we     = 1'b1;
                              store_status = STORE_STORED;
                              report       = 1'b1;
                              from_count   = 1'b1;
                              rep_slot     = laps_ff[SLOT_W-1:0];
                              laps_in      = CNT_W'(laps_ff + 1'b1);
                           end else begin
                              store_status = STORE_FULL;
                           end
                           if (mode_ff == MODE_PAUSE) begin
                              running_in = 1'b0;
                              clear      = 1'b1;
                           end
                        end
                        MODE_VIEW: begin
                           if (view_ff != '0) begin
                              view_in = SLOT_W'(view_ff - 1'b1);
                           end
                           show = 1'b1;
                        end
                        MODE_DIM: begin
                           last_in = item_now_ms;
                           if (level_ff != 3'd0) begin
                              level_in = 3'(level_ff - 1'b1);
                           end
                        end
                        default: ;
                     endcase
                  end
                  KEY_SELECT: begin
                     if (mode_ff == MODE_PAUSE) begin
                        press_in = item_now_ms;
                     end
                  end
                  default: ;
               endcase
            end
         end
         OP_RELEASE: begin
            if (item_key == KEY_SELECT) begin
               case (mode_ff)
                  MODE_PAUSE: begin
                     if (hold_time < {16'd0, long_press_ff}) begin
                        mode_in = MODE_VIEW;
                        view_in = '0;
                        show    = 1'b1;
                     end else begin
                        mode_in = MODE_DIM;
                        last_in = item_now_ms;
                     end
                  end
                  MODE_VIEW, MODE_DIM: mode_in = MODE_PAUSE;
                  default: ;
               endcase
            end
         end
         OP_POLL: begin
            if (mode_ff == MODE_DIM && idle_time >= {16'd0, idle_timeout_ff}) begin
               mode_in = MODE_PAUSE;
            end
         end
         default: ;
      endcase

      if (show) begin
         if (laps_ff == '0) begin
            view_status = VIEW_EMPTY;
         end else begin
            if (CNT_W'(view_in) >= laps_ff) begin
               view_in = SLOT_W'(laps_ff - 1'b1);
            end
            view_status = VIEW_SHOWN;
            report      = 1'b1;
            rep_slot    = view_in;
         end
      end
   end

   always_comb begin
      core.mode         = mode_code(mode_in);
      core.running      = running_in;
      core.clear_count  = clear;
      core.store_status = store_status;
      core.lap_slot     = 4'(rep_slot);
      core.view_status  = view_status;
      core.dim_level    = level_in;
      core.pwm_duty     = duty_tab[level_in];
      core.dim_percent  = pct_tab[level_in];
      if (!report) begin
         lap_value = '0;
      end else if (from_count) begin
         lap_value = item_count_value;
      end else begin
         lap_value = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         running_ff      <= 1'b0;
         laps_ff         <= '0;
         view_ff         <= '0;
         press_ff        <= '0;
         last_ff         <= '0;
         level_ff        <= LEVEL_RESET;
         long_press_ff   <= LONG_PRESS_RESET;
         idle_timeout_ff <= IDLE_TIMEOUT_RESET;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_LONG_PRESS:   long_press_ff   <= csr_write_data;
               CSR_IDLE_TIMEOUT: idle_timeout_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (fire) begin
            mode_ff    <= mode_in;
            running_ff <= running_in;
            laps_ff    <= laps_in;
            view_ff    <= view_in;
            press_ff   <= press_in;
            last_ff    <= last_in;
            level_ff   <= level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && store_we) begin
         lap_store[laps_ff[SLOT_W-1:0]] <= item_count_value;
      end
   end

endmodule

`default_nettype wire

[rtl/core/slmc_fmt.sv]
// ----------------------------------------------------------------------------
// Stopwatch lap mode controller lap formatter
// Four-register pipeline that splits the reported lap count into minutes,
// seconds and tenths by reciprocal multiplication, with its own flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module slmc_fmt (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire slmc_pkg::rsp_core_type   in_core,
   input  wire logic [31:0]              in_lap_value,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output slmc_pkg::rsp_core_type        out_core,
   output logic [22:0]                   out_minutes,
   output logic [5:0]                    out_seconds,
   output logic [3:0]                    out_tenths
);
   import slmc_pkg::*;

   logic         v1_ff, v2_ff, v3_ff, v4_ff;
   logic         rdy1, rdy2, rdy3, rdy4;
   rsp_core_type c1_ff, c2_ff, c3_ff, c4_ff;
   logic [31:0]  lap1_ff;
   logic [28:0]  q10_2_ff, q10_3_ff;
   logic [3:0]   low_2_ff;
   logic [3:0]   tenths_3_ff, tenths_4_ff;
   logic [22:0]  min_3_ff, min_4_ff;
   logic [5:0]   sec_4_ff;
   logic [63:0]  prod10;
   logic [63:0]  prod15;
   logic [26:0]  q10_quarter;
   logic [31:0]  q10_times_ten;
   logic [3:0]   tenths_in;
   logic [28:0]  min_times_sixty;
   logic [28:0]  sec_wide;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign prod10          = {32'd0, lap1_ff} * {32'd0, DIV10_MAGIC};
   assign q10_quarter     = q10_2_ff[28:2];
   assign prod15          = {5'd0, q10_quarter} * {32'd0, DIV15_MAGIC};
   assign q10_times_ten   = {q10_2_ff, 3'b000} + {2'b00, q10_2_ff, 1'b0};
   assign tenths_in       = low_2_ff - q10_times_ten[3:0];
   assign min_times_sixty = {min_3_ff, 6'd0} - {4'd0, min_3_ff, 2'd0};
   assign sec_wide        = q10_3_ff - min_times_sixty;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         c1_ff   <= in_core;
         lap1_ff <= in_lap_value;
      end
      if (rdy2) begin
         c2_ff    <= c1_ff;
         q10_2_ff <= prod10[63:35];
         low_2_ff <= lap1_ff[3:0];
      end
      if (rdy3) begin
         c3_ff       <= c2_ff;
         q10_3_ff    <= q10_2_ff;
         tenths_3_ff <= tenths_in;
         min_3_ff    <= prod15[57:35];
      end
      if (rdy4) begin
         c4_ff       <= c3_ff;
         tenths_4_ff <= tenths_3_ff;
         min_4_ff    <= min_3_ff;
         sec_4_ff    <= sec_wide[5:0];
      end
   end

   assign out_valid   = v4_ff;
   assign out_core    = c4_ff;
   assign out_minutes = min_4_ff;
   assign out_seconds = sec_4_ff;
   assign out_tenths  = tenths_4_ff;

endmodule

`default_nettype wire

[rtl/core/stopwatch_lap_mode_controller.sv]
// ----------------------------------------------------------------------------
// Stopwatch lap mode controller
// Keypad mode control for a decisecond stopwatch with lap memory and a
// stepped backlight dimmer.
//
// Each beat on the req channel is one keypad event (press, release or poll)
// with a millisecond timestamp and the current count from the external
// counter. Each event produces exactly one beat on the rsp channel with the
// new mode, the run and clear commands, lap store and view status, the lap
// split into minutes, seconds and tenths, and the backlight level and duty.
// An accepted event passes the input register, where the mode logic updates
// the state, and then the four registers of the lap formatter, whose two
// reciprocal multiplications set that depth. One event is taken every cycle
// while the receiver takes results. When the receiver stalls, the pipeline
// fills and req_ready falls only once every stage holds a beat.
// The csr port writes the long press and idle timeout thresholds with a
// single-cycle enable; write them while no event is in flight.
// Reset is synchronous; it returns to the not started mode, empties the lap
// store and sets the thresholds to 3000 ms and 5000 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module stopwatch_lap_mode_controller #(
   parameter int LAP_SLOTS  = 10,
   parameter int DIM_LEVELS = 5
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [slmc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [slmc_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_operation,
   input  wire logic [1:0]                         req_key,
   input  wire logic [31:0]                        req_now_ms,
   input  wire logic [31:0]                        req_count_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [2:0]                              rsp_mode,
   output logic                                    rsp_running,
   output logic                                    rsp_clear_count,
   output logic [1:0]                              rsp_store_status,
   output logic [3:0]                              rsp_lap_slot,
   output logic [22:0]                             rsp_lap_minutes,
   output logic [5:0]                              rsp_lap_seconds,
   output logic [3:0]                              rsp_lap_tenths,
   output logic [1:0]                              rsp_view_status,
   output logic [2:0]                              rsp_dim_level,
   output logic [7:0]                              rsp_pwm_duty,
   output logic [6:0]                              rsp_dim_percent
);
   import slmc_pkg::*;

   logic         s0_valid_ff;
   logic [1:0]   s0_operation_ff;
   logic [1:0]   s0_key_ff;
   logic [31:0]  s0_now_ms_ff;
   logic [31:0]  s0_count_value_ff;
   logic         fmt_ready;
   logic         fire;
   rsp_core_type core;
   rsp_core_type out_core;
   logic [31:0]  lap_value;

   assign req_ready = !s0_valid_ff || fmt_ready;
   assign fire      = s0_valid_ff && fmt_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s0_operation_ff   <= req_operation;
         s0_key_ff         <= req_key;
         s0_now_ms_ff      <= req_now_ms;
         s0_count_value_ff <= req_count_value;
      end
   end

   slmc_ctrl #(
      .LAP_SLOTS  (LAP_SLOTS),
      .DIM_LEVELS (DIM_LEVELS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fire             (fire),
      .item_operation   (s0_operation_ff),
      .item_key         (s0_key_ff),
      .item_now_ms      (s0_now_ms_ff),
      .item_count_value (s0_count_value_ff),
      .core             (core),
      .lap_value        (lap_value)
   );

   slmc_fmt u_fmt (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (fire),
      .in_ready     (fmt_ready),
      .in_core      (core),
      .in_lap_value (lap_value),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_core     (out_core),
      .out_minutes  (rsp_lap_minutes),
      .out_seconds  (rsp_lap_seconds),
      .out_tenths   (rsp_lap_tenths)
   );

   assign rsp_mode         = out_core.mode;
   assign rsp_running      = out_core.running;
   assign rsp_clear_count  = out_core.clear_count;
   assign rsp_store_status = out_core.store_status;
   assign rsp_lap_slot     = out_core.lap_slot;
   assign rsp_view_status  = out_core.view_status;
   assign rsp_dim_level    = out_core.dim_level;
   assign rsp_pwm_duty     = out_core.pwm_duty;
   assign rsp_dim_percent  = out_core.dim_percent;

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && !fmt_ready |=> s0_valid_ff)
      else $error("input register dropped an event that was not passed on");

   a_running_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_running |-> rsp_mode == MODE_CODE_COUNT)
      else $error("running reported outside counting mode");

   a_view_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_view_status != VIEW_NONE |-> rsp_mode == MODE_CODE_VIEW)
      else $error("lap view status outside the lap viewer");

   a_store_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_status != STORE_NONE
      |-> rsp_mode == MODE_CODE_COUNT || rsp_mode == MODE_CODE_PAUSE)
      else $error("lap store status outside counting or pause");

endmodule

`default_nettype wire
